// ===== src/dwaa_pkg.sv =====
// ----------------------------------------------------------------------------
// dwaa_pkg: shared types and constants for the dual window average alarm
// Window and record sizes, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwaa_pkg;

    // Sizing
    localparam int WINDOW       = 30;
    localparam int RECORD_BYTES = 8;

    // Field widths
    localparam int CODE_W    = 10;
    localparam int SUM_W     = 15;
    localparam int LIMIT_W   = 10;
    localparam int BAR_W     = 4;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;

    // Derived widths
    localparam int CODE_MAX  = (1 << CODE_W) - 1;
    localparam int SUM_MAX   = (1 << SUM_W) - 1;
    localparam int TOTAL_W   = $clog2(WINDOW * CODE_MAX + 1);
    localparam int SLOT_W    = $clog2(WINDOW);
    // wide enough for the exact total and for three times a step value
    localparam int WIDE_W    = (TOTAL_W > SUM_W + 2) ? TOTAL_W : SUM_W + 2;
    localparam int LOG_SUM_W = $clog2((1 << LIMIT_W) + RECORD_BYTES);

    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [TOTAL_W-1:0]   total_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [LIMIT_W-1:0]   limit_t;
    typedef logic [BAR_W-1:0]     bar_t;
    typedef logic [WIDE_W-1:0]    wide_t;
    typedef logic [LOG_SUM_W-1:0] log_sum_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;

    // Configuration register indexes
    localparam cfg_idx_t REG_TEMP_ALARM = cfg_idx_t'(0);
    localparam cfg_idx_t REG_LIGHT_STEP = cfg_idx_t'(1);
    localparam cfg_idx_t REG_LOG_LIMIT  = cfg_idx_t'(2);

    // Register reset values
    localparam sum_t   TEMP_ALARM_RST = sum_t'(4480);
    localparam sum_t   LIGHT_STEP_RST = sum_t'(6000);
    localparam limit_t LOG_LIMIT_RST  = limit_t'(892);

    // Window total clipped to the output field
    function automatic sum_t sat_sum(input total_t total);
        wide_t wide;
        wide = wide_t'(total);
        if (wide > wide_t'(SUM_MAX))
            return sum_t'(SUM_MAX);
        else
            return sum_t'(wide);
    endfunction

endpackage

// ===== src/dual_window_average_alarm.sv =====
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle while out_stall is low; the window sums
// are updated in a single read, subtract and add on the ring slot register.
// Reset (rst_n low, asynchronous) clears both rings, the sums, the ring slot
// and the log pointer and loads the configuration registers with defaults.
// ----------------------------------------------------------------------------
// dual_window_average_alarm: moving window sums with light bar and alarm
// Two 10-bit sensor codes per request feed two rings of WINDOW entries. The
// block returns both window sums, a four-step light bar, a temperature alarm
// and the log slot address, which advances by RECORD_BYTES on each alarm.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_window_average_alarm
    import dwaa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,

    // configuration write port
    input  logic      cfg_write,
    input  cfg_idx_t  cfg_index,
    input  cfg_data_t cfg_data,

    // input channel
    input  logic      in_valid,
    output logic      in_stall,
    input  code_t     temp_code,
    input  code_t     light_code,

    // result channel
    output logic      out_valid,
    input  logic      out_stall,
    output sum_t      temp_sum,
    output sum_t      light_sum,
    output bar_t      light_bar,
    output logic      alarm,
    output logic      log_write,
    output limit_t    log_address
);

    // Configuration registers
    sum_t   temp_alarm_sum_reg;
    sum_t   light_step_sum_reg;
    limit_t log_limit_reg;

    // Input register
    logic   in_valid_reg;
    code_t  temp_code_reg;
    code_t  light_code_reg;

    // Window state
    code_t  temp_ring_reg  [WINDOW];
    code_t  light_ring_reg [WINDOW];
    total_t temp_total_reg;
    total_t light_total_reg;
    slot_t  ring_slot_reg;
    limit_t log_pointer_reg;

    // Result register
    logic   out_valid_reg;
    sum_t   temp_sum_reg;
    sum_t   light_sum_reg;
    bar_t   light_bar_reg;
    logic   alarm_reg;
    limit_t log_address_reg;

    // Next values
    total_t   temp_total_next;
    total_t   light_total_next;
    slot_t    ring_slot_next;
    limit_t   log_pointer_next;
    limit_t   log_address_next;
    bar_t     light_bar_next;
    logic     alarm_next;
    wide_t    light_wide;
    wide_t    step_wide;
    log_sum_t log_sum;

    logic advance;
    logic fire;

    // Handshake: the result register frees up when empty or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // Window update and threshold compares
    always_comb
    begin
        temp_total_next  = temp_total_reg + total_t'(temp_code_reg)
                         - total_t'(temp_ring_reg[ring_slot_reg]);
        light_total_next = light_total_reg + total_t'(light_code_reg)
                         - total_t'(light_ring_reg[ring_slot_reg]);

        ring_slot_next = (ring_slot_reg == slot_t'(WINDOW - 1))
                       ? '0 : ring_slot_reg + slot_t'(1);

        // light bar: step multiples 0, 1, 2 and 3
        light_wide = wide_t'(light_total_next);
        step_wide  = wide_t'(light_step_sum_reg);
        light_bar_next[0] = light_wide > '0;
        light_bar_next[1] = light_wide > step_wide;
        light_bar_next[2] = light_wide > (step_wide << 1);
        light_bar_next[3] = light_wide > ((step_wide << 1) + step_wide);

        alarm_next = wide_t'(temp_total_next) > wide_t'(temp_alarm_sum_reg);

        // log slot advance, wraps to zero at or past the limit
        log_sum = log_sum_t'(log_pointer_reg) + log_sum_t'(RECORD_BYTES);
        if (alarm_next)
        begin
            log_address_next = log_pointer_reg;
            if (log_sum >= log_sum_t'(log_limit_reg))
                log_pointer_next = '0;
            else
                log_pointer_next = limit_t'(log_sum);
        end
        else
        begin
            log_address_next = '0;
            log_pointer_next = log_pointer_reg;
        end
    end

    // Configuration, handshake and window control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_alarm_sum_reg <= TEMP_ALARM_RST;
            light_step_sum_reg <= LIGHT_STEP_RST;
            log_limit_reg      <= LOG_LIMIT_RST;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            temp_total_reg     <= '0;
            light_total_reg    <= '0;
            ring_slot_reg      <= '0;
            log_pointer_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TEMP_ALARM: temp_alarm_sum_reg <= sum_t'(cfg_data);
                    REG_LIGHT_STEP: light_step_sum_reg <= sum_t'(cfg_data);
                    REG_LOG_LIMIT:  log_limit_reg      <= limit_t'(cfg_data);
                    default:        ;
                endcase
            end

            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;

            if (fire)
            begin
                temp_total_reg  <= temp_total_next;
                light_total_reg <= light_total_next;
                ring_slot_reg   <= ring_slot_next;
                log_pointer_reg <= log_pointer_next;
            end
        end
    end

    // Sample rings, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                temp_ring_reg[i]  <= '0;
                light_ring_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            temp_ring_reg[ring_slot_reg]  <= temp_code_reg;
            light_ring_reg[ring_slot_reg] <= light_code_reg;
        end
    end

    // Input and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            temp_code_reg  <= temp_code;
            light_code_reg <= light_code;
        end
        if (fire)
        begin
            temp_sum_reg    <= sat_sum(temp_total_next);
            light_sum_reg   <= sat_sum(light_total_next);
            light_bar_reg   <= light_bar_next;
            alarm_reg       <= alarm_next;
            log_address_reg <= log_address_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign temp_sum    = temp_sum_reg;
    assign light_sum   = light_sum_reg;
    assign light_bar   = light_bar_reg;
    assign alarm       = alarm_reg;
    assign log_write   = alarm_reg;
    assign log_address = log_address_reg;

`ifndef ASSERT_OFF
    // ring slot stays inside the window
    assert property (@(posedge clk) disable iff (!rst_n)
        ring_slot_reg <= slot_t'(WINDOW - 1))
        else $error("ring slot out of window");

    // running totals never exceed a full window of maximum codes
    assert property (@(posedge clk) disable iff (!rst_n)
        temp_total_reg <= total_t'(WINDOW * CODE_MAX) &&
        light_total_reg <= total_t'(WINDOW * CODE_MAX))
        else $error("window total out of range");

    // no log slot is reported without an alarm
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !alarm_reg |-> log_address_reg == '0)
        else $error("log address without alarm");

    // light bar fills from the bottom up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> light_bar_reg == 4'b0000 || light_bar_reg == 4'b0001 ||
            light_bar_reg == 4'b0011 || light_bar_reg == 4'b0111 ||
            light_bar_reg == 4'b1111)
        else $error("light bar not a thermometer code");
`endif

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for dual_window_average_alarm
// Sends pairs of sensor codes as bursts with random gaps into the block and
// stalls the result side on a changing pattern. A scoreboard keeps its own
// copy of both rings, the window sums and the log pointer, and compares every
// result field by field. The registers are rewritten between phases,
// extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import dwaa_pkg::*;

    localparam int       LATENCY     = 2;
    localparam int       CYCLE_LIMIT = 300000;
    localparam int       PHASES      = 10;
    localparam int       DIRECTED    = 20;
    localparam cfg_idx_t REG_SPARE   = cfg_idx_t'(3);

    typedef struct packed {
        sum_t   temp_sum;
        sum_t   light_sum;
        bar_t   light_bar;
        logic   alarm;
        logic   log_write;
        limit_t log_address;
    } window_result_t;

    // Scoreboard: mirrors the rings, sums and log pointer, queues what is due
    class window_scoreboard;
        int unsigned    temp_ring [WINDOW];
        int unsigned    light_ring [WINDOW];
        int unsigned    temp_total;
        int unsigned    light_total;
        int unsigned    ring_slot;
        int unsigned    log_pointer;
        int unsigned    alarm_level;
        int unsigned    bar_step;
        int unsigned    wrap_limit;
        window_result_t due_q [$];
        int             errors;
        int             requests;
        int             checked;
        int             alarms;
        int             wraps;

        function new();
            foreach (temp_ring[k])
            begin
                temp_ring[k]  = 0;
                light_ring[k] = 0;
            end
            temp_total  = 0;
            light_total = 0;
            ring_slot   = 0;
            log_pointer = 0;
            alarm_level = 32'(TEMP_ALARM_RST);
            bar_step    = 32'(LIGHT_STEP_RST);
            wrap_limit  = 32'(LOG_LIMIT_RST);
            errors      = 0;
            requests    = 0;
            checked     = 0;
            alarms      = 0;
            wraps       = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, cfg_data_t data);
            case (idx)
                REG_TEMP_ALARM: alarm_level = 32'(data);
                REG_LIGHT_STEP: bar_step    = 32'(data);
                REG_LOG_LIMIT:  wrap_limit  = 32'(data[LIMIT_W-1:0]);
                default: ;
            endcase
        endfunction

        // Work out the result of one accepted request
        function void note_request(code_t t_code, code_t l_code);
            window_result_t r;
            int unsigned    slot;
            int unsigned    next_ptr;
            slot = ring_slot;
            temp_total  = temp_total - temp_ring[slot] + t_code;
            light_total = light_total - light_ring[slot] + l_code;
            temp_ring[slot]  = t_code;
            light_ring[slot] = l_code;
            ring_slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;

            r = '0;
            r.temp_sum  = (temp_total > SUM_MAX) ? sum_t'(SUM_MAX) : sum_t'(temp_total);
            r.light_sum = (light_total > SUM_MAX) ? sum_t'(SUM_MAX) : sum_t'(light_total);
            // products kept exact, so a large step leaves upper bits clear
            for (int i = 0; i < BAR_W; i++)
                if (light_total > i * bar_step)
                    r.light_bar[i] = 1'b1;

            if (temp_total > alarm_level)
            begin
                r.alarm       = 1'b1;
                r.log_write   = 1'b1;
                r.log_address = limit_t'(log_pointer);
                next_ptr      = log_pointer + RECORD_BYTES;
                if (next_ptr >= wrap_limit)
                begin
                    log_pointer = 0;
                    wraps++;
                end
                else
                    log_pointer = next_ptr;
                alarms++;
            end
            requests++;
            due_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
            if (exp_v !== got_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(window_result_t got);
            window_result_t want;
            if (due_q.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                errors++;
                return;
            end
            want = due_q.pop_front();
            checked++;
            compare_field("temp_sum", 16'(want.temp_sum), 16'(got.temp_sum));
            compare_field("light_sum", 16'(want.light_sum), 16'(got.light_sum));
            compare_field("light_bar", 16'(want.light_bar), 16'(got.light_bar));
            compare_field("alarm", 16'(want.alarm), 16'(got.alarm));
            compare_field("log_write", 16'(want.log_write), 16'(got.log_write));
            compare_field("log_address", 16'(want.log_address), 16'(got.log_address));
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      cfg_write  = 1'b0;
    cfg_idx_t  cfg_index  = REG_TEMP_ALARM;
    cfg_data_t cfg_data   = '0;
    logic      in_valid   = 1'b0;
    logic      in_stall;
    code_t     temp_code  = '0;
    code_t     light_code = '0;
    logic      out_valid;
    logic      out_stall  = 1'b0;
    sum_t      temp_sum;
    sum_t      light_sum;
    bar_t      light_bar;
    logic      alarm;
    logic      log_write;
    limit_t    log_address;

    window_scoreboard sb = new();
    window_result_t   observed;
    bit               quiet       = 1'b0;
    int               burst_left  = 0;
    int               cycle_count = 0;
    logic [15:0]      stall_pattern = '0;
    int               stall_pos   = 0;

    dual_window_average_alarm uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .temp_code   (temp_code),
        .light_code  (light_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .temp_sum    (temp_sum),
        .light_sum   (light_sum),
        .light_bar   (light_bar),
        .alarm       (alarm),
        .log_write   (log_write),
        .log_address (log_address)
    );

    always #5 clk = ~clk;

    // Result side: stall on a pattern that is reloaded when the position wraps to zero
    always @(negedge clk)
    begin
        if (stall_pos == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pattern = 16'h0000;
                1:       stall_pattern = 16'($urandom & $urandom);
                2:       stall_pattern = 16'($urandom);
                default: stall_pattern = 16'($urandom | $urandom);
            endcase
        end
        out_stall <= rst_n && !quiet && stall_pattern[stall_pos % 16];
        stall_pos = (stall_pos + 1) % 64;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            observed.temp_sum    = temp_sum;
            observed.light_sum   = light_sum;
            observed.light_bar   = light_bar;
            observed.alarm       = alarm;
            observed.log_write   = log_write;
            observed.log_address = log_address;
            sb.check_result(observed);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic code_t clip_code(int v);
        if (v < 0)
            return '0;
        else if (v > CODE_MAX)
            return code_t'(CODE_MAX);
        else
            return code_t'(v);
    endfunction

    // Send one request; valid stays high within a burst
    task automatic send_request(code_t t_code, code_t l_code);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = quiet ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        temp_code  <= t_code;
        light_code <= l_code;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_request(t_code, l_code);
        burst_left--;
    endtask

    task automatic close_burst();
        @(negedge clk);
        in_valid  <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Rewrite all registers back to back, optionally poking the unused index
    task automatic load_config(cfg_data_t alarm_v, cfg_data_t step_v, cfg_data_t limit_v,
                               bit poke_spare);
        cfg_idx_t  idx_list [4];
        cfg_data_t data_list [4];
        int        n;
        idx_list[0]  = REG_TEMP_ALARM;
        data_list[0] = alarm_v;
        idx_list[1]  = REG_LIGHT_STEP;
        data_list[1] = step_v;
        idx_list[2]  = REG_LOG_LIMIT;
        data_list[2] = limit_v;
        idx_list[3]  = REG_SPARE;
        data_list[3] = cfg_data_t'($urandom);
        n = poke_spare ? 4 : 3;
        wait_idle();
        for (int k = 0; k < n; k++)
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data  <= data_list[k];
            @(posedge clk);
            sb.write_reg(idx_list[k], data_list[k]);
        end
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Slowly drifting sensor levels with noise, plus random and extreme codes
    task automatic run_random(int count, int temp_level, int light_level);
        int    r;
        code_t t_code;
        code_t l_code;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 63) == 0)
                temp_level = $urandom_range(0, CODE_MAX);
            if ($urandom_range(0, 63) == 0)
                light_level = $urandom_range(0, CODE_MAX);
            r = $urandom_range(0, 15);
            if (r < 2)
            begin
                t_code = code_t'($urandom_range(0, CODE_MAX));
                l_code = code_t'($urandom_range(0, CODE_MAX));
            end
            else if (r == 2)
            begin
                t_code = $urandom_range(0, 1) ? code_t'(CODE_MAX) : '0;
                l_code = $urandom_range(0, 1) ? code_t'(CODE_MAX) : '0;
            end
            else
            begin
                temp_level  = int'(clip_code(temp_level + int'($urandom_range(0, 40)) - 20));
                light_level = int'(clip_code(light_level + int'($urandom_range(0, 40)) - 20));
                t_code = clip_code(temp_level + int'($urandom_range(0, 60)) - 30);
                l_code = clip_code(light_level + int'($urandom_range(0, 60)) - 30);
            end
            send_request(t_code, l_code);
        end
    endtask

    // Directed requests: window filling from zero, full-scale codes,
    // alternating bit patterns, crossing the default alarm level
    int dir_temp [DIRECTED] = '{0, 1023, 1023, 1023, 1023, 1023, 341, 682, 1, 512,
                                0, 1023, 1023, 1023, 1023, 1023, 0, 0, 1023, 0};
    int dir_light [DIRECTED] = '{0, 0, 1023, 1023, 1023, 1023, 682, 341, 512, 1,
                                 1023, 1023, 1023, 1023, 1023, 1023, 1023, 0, 0, 1023};

    // Main sequence
    initial
    begin
        cfg_data_t limit_v;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED; k++)
            send_request(code_t'(dir_temp[k]), code_t'(dir_light[k]));

        for (int p = 0; p < PHASES; p++)
        begin
            close_burst();
            case (p)
                0: ;    // reset values stay in place
                1: load_config('0, '0, cfg_data_t'(RECORD_BYTES), 1'b1);
                2: load_config(cfg_data_t'(SUM_MAX), cfg_data_t'(SUM_MAX),
                               cfg_data_t'(CODE_MAX), 1'b0);
                // limit below the record size, upper data bits set
                3: load_config(cfg_data_t'(9000), cfg_data_t'(3000), 15'h7C05, 1'b0);
                // limit of zero, upper data bits set
                4: load_config(cfg_data_t'($urandom_range(0, 30690)),
                               cfg_data_t'($urandom_range(0, 12000)), 15'h7C00, 1'b1);
                default:
                begin
                    limit_v = cfg_data_t'($urandom_range(0, CODE_MAX));
                    limit_v[CFG_W-1:LIMIT_W] = (CFG_W-LIMIT_W)'($urandom);
                    load_config(cfg_data_t'($urandom_range(0, 30690)),
                                cfg_data_t'($urandom_range(0, 12000)), limit_v,
                                1'($urandom_range(0, 1)));
                end
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            // first phase runs long and warm so the log pointer wraps at 892
            if (p == 0)
                run_random(250, 800, $urandom_range(0, CODE_MAX));
            else
                run_random(110, $urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX));
        end
        close_burst();
        wait_idle();

        $display("Sent %0d requests across %0d register settings; %0d alarms, %0d log wraps.",
                 sb.requests, PHASES, sb.alarms, sb.wraps);
        $display("Checked %0d results, %0d field mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
src/dwaa_pkg.sv
src/dual_window_average_alarm.sv
dv/tb.sv
